// File: src/mips_subset_instruction_executor_defines.svh
// Assertion macros for the executor's top-level RTL file.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Plain property under the clock, off while reset is asserted.
`define MSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication form: when ante holds, cons holds in the same cycle.
`define MSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication form: when ante holds, cons holds in the next cycle.
`define MSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mse_pkg.sv
// Package: types, constants and decode helpers of the MIPS subset executor.
`default_nettype none
package mse_pkg;

  localparam int unsigned PROGRAM_WORDS = 1024 * 32;
  localparam int unsigned DATA_WORDS    = 1024 * 32;
  localparam int unsigned PROG_AW       = $clog2(PROGRAM_WORDS);
  localparam int unsigned DATA_AW       = $clog2(DATA_WORDS);
  localparam int unsigned REG_WORDS     = 32;
  localparam int unsigned REG_AW        = 5;
  localparam int unsigned CLR_DEPTH     = (PROGRAM_WORDS > DATA_WORDS) ?
                                          PROGRAM_WORDS : DATA_WORDS;
  localparam int unsigned CLR_AW        = $clog2(CLR_DEPTH);
  localparam int unsigned CMP_W         = 17;
  localparam int unsigned PC_W          = 15;
  localparam int unsigned CFG_AW        = 3;

  localparam logic [31:0] DATA_BASE  = 32'h1000_0000;
  localparam logic [31:0] DATA_BYTES = 32'(DATA_WORDS * 4);

  // item kinds
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_RDREG = 2'd2;
  localparam logic [1:0] OP_RDMEM = 2'd3;

  // result status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_UNKNOWN = 3'd1;
  localparam logic [2:0] STS_HALTED  = 3'd2;
  localparam logic [2:0] STS_LIMIT   = 3'd3;
  localparam logic [2:0] STS_RANGE   = 3'd4;

  // register index on the configuration port
  localparam logic REG_LIMIT = 1'b0;

  // opcodes
  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_J     = 6'd2;
  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_BNE   = 6'd5;
  localparam logic [5:0] OPC_ADDI  = 6'd8;
  localparam logic [5:0] OPC_SLTI  = 6'd10;
  localparam logic [5:0] OPC_ANDI  = 6'd12;
  localparam logic [5:0] OPC_ORI   = 6'd13;
  localparam logic [5:0] OPC_LUI   = 6'd15;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_NOP = 6'd0;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_SLT
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_CLEAR = 10'b00_0000_0010,
    ST_FETCH = 10'b00_0000_0100,
    ST_RDA   = 10'b00_0000_1000,
    ST_RDB   = 10'b00_0001_0000,
    ST_EXEC  = 10'b00_0010_0000,
    ST_ADDR  = 10'b00_0100_0000,
    ST_LOAD  = 10'b00_1000_0000,
    ST_BR    = 10'b01_0000_0000,
    ST_RESP  = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_REG,
    VAL_DATA
  } val_sel_e;

  // R-type word that the core knows: a listed funct, or the all-zero nop
  function automatic logic rtype_known(input logic [31:0] w);
    logic [5:0] fn;
    fn = w[5:0];
    rtype_known = (fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT}) ||
                  ((fn == FN_NOP) && (w[25:6] == 20'd0));
  endfunction

endpackage
`default_nettype wire

// File: src/mips_subset_instruction_executor.sv
// Top level: sequencer, state and memories of the MIPS subset executor.
// Program loads, refused executes and reads go from idle to the response state; an executed
// instruction is fetched, then ends (empty slot or unknown word) or reads two registers over
// one port and runs the shared ALU, plus an address pass (store), a branch pass (taken branch)
// or an address pass and a load step (load). One request at a time; the next is taken once the
// sequencer is back in idle, entered as the result is posted. Reset: all control clears
// at once, then a clearing pass sets data to all ones, slots invalid, registers to zero.
`default_nettype none
`include "mips_subset_instruction_executor_defines.svh"
module mips_subset_instruction_executor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [14:0]                 index_i,
  input  wire logic [31:0]                 word_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       status_o,
  output logic [31:0]                      read_value_o,
  output logic [14:0]                      pc_index_o,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mse_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // sequencer and architectural state
  mse_pkg::state_e    st_q, st_d;
  mse_pkg::val_sel_e  vsel_q, vsel_d;
  logic [mse_pkg::CLR_AW-1:0] cnt_q, cnt_d;
  logic [14:0]        pc_q, pc_d;
  logic               halted_q, halted_d;
  logic [31:0]        count_q, count_d;
  logic [31:0]        limit_q;
  logic [2:0]         status_q, status_d;
  logic [31:0]        ir_q, ir_d;
  logic [31:0]        a_q, a_d;
  logic [31:0]        b_q, b_d;
  logic [31:0]        alu_q, alu_d;

  // result register
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic [31:0]        out_value_q;
  logic [14:0]        out_pc_q;

  // memory ports
  logic                         prog_we, prog_re;
  logic [mse_pkg::PROG_AW-1:0]  prog_waddr, prog_raddr;
  logic [32:0]                  prog_wdata, prog_rdata;
  logic                         data_we, data_re;
  logic [mse_pkg::DATA_AW-1:0]  data_waddr, data_raddr;
  logic [31:0]                  data_wdata, data_rdata;
  logic                         reg_we, reg_re;
  logic [mse_pkg::REG_AW-1:0]   reg_waddr, reg_raddr;
  logic [31:0]                  reg_wdata, reg_rdata;

  mse_pkg::alu_req_t  alu_req;
  logic [31:0]        alu_res;
  logic               alu_zero;

  logic               in_acc, out_free, cfg_wr;
  logic [14:0]        pc_inc;
  logic [5:0]         opc, fn;
  logic [31:0]        simm, zimm;
  logic [4:0]         rs_f, rt, rd;
  logic               wr_en;
  logic [4:0]         wr_dst;
  logic [31:0]        sel_value;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != mse_pkg::ST_IDLE);
  assign pc_inc   = pc_q + 15'd1;

  // decode fields of the latched instruction; rs comes from the program read data
  assign opc  = ir_q[31:26];
  assign fn   = ir_q[5:0];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign zimm = {16'd0, ir_q[15:0]};
  assign rs_f = prog_rdata[25:21];

  // configuration port: one register, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[mse_pkg::CFG_AW-1:2] == mse_pkg::REG_LIMIT);
  assign prdata = (paddr[mse_pkg::CFG_AW-1:2] == mse_pkg::REG_LIMIT) ? limit_q : 32'd0;

  mse_ram #(.WIDTH(33), .DEPTH(mse_pkg::PROGRAM_WORDS)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .re_i    (prog_re),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::DATA_WORDS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::REG_WORDS)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .re_i    (reg_re),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  mse_alu u_alu (
    .req_i    (alu_req),
    .result_o (alu_res),
    .zero_o   (alu_zero)
  );

  // sequencer
  always_comb begin
    st_d     = st_q;
    vsel_d   = vsel_q;
    cnt_d    = cnt_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    count_d  = count_q;
    status_d = status_q;
    ir_d     = ir_q;
    a_d      = a_q;
    b_d      = b_q;
    alu_d    = alu_q;

    prog_we = 1'b0; prog_waddr = '0; prog_wdata = '0;
    prog_re = 1'b0; prog_raddr = '0;
    data_we = 1'b0; data_waddr = '0; data_wdata = '0;
    data_re = 1'b0; data_raddr = '0;
    reg_we  = 1'b0; reg_waddr  = '0; reg_wdata  = '0;
    reg_re  = 1'b0; reg_raddr  = '0;

    alu_req.op = mse_pkg::ALU_ADD;
    alu_req.a  = a_q;
    alu_req.b  = b_q;
    wr_en  = 1'b0;
    wr_dst = rt;

    case (st_q)
      mse_pkg::ST_CLEAR: begin
        // sweep all stores to their reset contents, one entry per cycle
        if ({1'b0, cnt_q} < (mse_pkg::CLR_AW+1)'(mse_pkg::PROGRAM_WORDS)) begin
          prog_we    = 1'b1;
          prog_waddr = mse_pkg::PROG_AW'(cnt_q);
        end
        if ({1'b0, cnt_q} < (mse_pkg::CLR_AW+1)'(mse_pkg::DATA_WORDS)) begin
          data_we    = 1'b1;
          data_waddr = mse_pkg::DATA_AW'(cnt_q);
          data_wdata = '1;
        end
        if ({1'b0, cnt_q} < (mse_pkg::CLR_AW+1)'(mse_pkg::REG_WORDS)) begin
          reg_we    = 1'b1;
          reg_waddr = mse_pkg::REG_AW'(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mse_pkg::CLR_AW'(mse_pkg::CLR_DEPTH - 1)) begin
          st_d = mse_pkg::ST_IDLE;
        end
      end

      mse_pkg::ST_IDLE: begin
        if (in_acc) begin
          status_d = mse_pkg::STS_OK;
          vsel_d   = mse_pkg::VAL_ZERO;
          st_d     = mse_pkg::ST_RESP;
          case (op_i)
            mse_pkg::OP_LOAD: begin
              if ({2'b0, index_i} < mse_pkg::CMP_W'(mse_pkg::PROGRAM_WORDS)) begin
                prog_we    = 1'b1;
                prog_waddr = mse_pkg::PROG_AW'(index_i);
                prog_wdata = {1'b1, word_i};
              end else begin
                status_d = mse_pkg::STS_RANGE;
              end
            end
            mse_pkg::OP_EXEC: begin
              if (halted_q) begin
                status_d = mse_pkg::STS_HALTED;
              end else if (count_q >= limit_q) begin
                status_d = mse_pkg::STS_LIMIT;
              end else begin
                count_d    = count_q + 32'd1;
                prog_re    = 1'b1;
                prog_raddr = mse_pkg::PROG_AW'(pc_q);
                st_d       = mse_pkg::ST_FETCH;
              end
            end
            mse_pkg::OP_RDREG: begin
              if (index_i[14:5] == 10'd0) begin
                reg_re    = 1'b1;
                reg_raddr = index_i[4:0];
                vsel_d    = mse_pkg::VAL_REG;
              end else begin
                status_d = mse_pkg::STS_RANGE;
              end
            end
            default: begin
              if ({2'b0, index_i} < mse_pkg::CMP_W'(mse_pkg::DATA_WORDS)) begin
                data_re    = 1'b1;
                data_raddr = mse_pkg::DATA_AW'(index_i);
                vsel_d     = mse_pkg::VAL_DATA;
              end else begin
                status_d = mse_pkg::STS_RANGE;
              end
            end
          endcase
        end
      end

      mse_pkg::ST_FETCH: begin
        ir_d = prog_rdata[31:0];
        // empty slot or unknown R-type word: advance and halt
        if (({2'b0, pc_q} >= mse_pkg::CMP_W'(mse_pkg::PROGRAM_WORDS)) || !prog_rdata[32] ||
            ((prog_rdata[31:26] == mse_pkg::OPC_RTYPE) &&
             !mse_pkg::rtype_known(prog_rdata[31:0]))) begin
          halted_d = 1'b1;
          pc_d     = pc_inc;
          status_d = mse_pkg::STS_UNKNOWN;
          st_d     = mse_pkg::ST_RESP;
        end else begin
          reg_re    = 1'b1;
          reg_raddr = rs_f;
          st_d      = mse_pkg::ST_RDA;
        end
      end

      mse_pkg::ST_RDA: begin
        a_d       = reg_rdata;
        reg_re    = 1'b1;
        reg_raddr = rt;
        st_d      = mse_pkg::ST_RDB;
      end

      mse_pkg::ST_RDB: begin
        b_d  = reg_rdata;
        st_d = mse_pkg::ST_EXEC;
      end

      mse_pkg::ST_EXEC: begin
        pc_d = pc_inc;
        st_d = mse_pkg::ST_RESP;
        case (opc)
          mse_pkg::OPC_RTYPE: begin
            wr_dst = rd;
            wr_en  = 1'b1;
            case (fn)
              mse_pkg::FN_ADD: alu_req.op = mse_pkg::ALU_ADD;
              mse_pkg::FN_SUB: alu_req.op = mse_pkg::ALU_SUB;
              mse_pkg::FN_AND: alu_req.op = mse_pkg::ALU_AND;
              mse_pkg::FN_OR:  alu_req.op = mse_pkg::ALU_OR;
              mse_pkg::FN_SLT: alu_req.op = mse_pkg::ALU_SLT;
              default:         wr_en      = 1'b0;
            endcase
          end
          mse_pkg::OPC_ADDI: begin
            alu_req.b = simm;
            wr_en     = 1'b1;
          end
          mse_pkg::OPC_ANDI: begin
            alu_req.op = mse_pkg::ALU_AND;
            alu_req.b  = zimm;
            wr_en      = 1'b1;
          end
          mse_pkg::OPC_ORI: begin
            alu_req.op = mse_pkg::ALU_OR;
            alu_req.b  = zimm;
            wr_en      = 1'b1;
          end
          mse_pkg::OPC_SLTI: begin
            alu_req.op = mse_pkg::ALU_SLT;
            alu_req.b  = simm;
            wr_en      = 1'b1;
          end
          mse_pkg::OPC_LUI: begin
            alu_req.op = mse_pkg::ALU_OR;
            alu_req.a  = 32'd0;
            alu_req.b  = {ir_q[15:0], 16'd0};
            wr_en      = 1'b1;
          end
          mse_pkg::OPC_LW, mse_pkg::OPC_SW: begin
            // first pass: base plus offset
            alu_req.b = simm;
            alu_d     = alu_res;
            pc_d      = pc_q;
            st_d      = mse_pkg::ST_ADDR;
          end
          mse_pkg::OPC_BEQ, mse_pkg::OPC_BNE: begin
            alu_req.op = mse_pkg::ALU_SUB;
            if (alu_zero ^ (opc == mse_pkg::OPC_BNE)) begin
              pc_d = pc_q;
              st_d = mse_pkg::ST_BR;
            end
          end
          mse_pkg::OPC_J: begin
            pc_d = ir_q[mse_pkg::PC_W-1:0];
          end
          default: ;  // unlisted opcode runs as a nop
        endcase
        if (wr_en && (wr_dst != 5'd0)) begin
          reg_we    = 1'b1;
          reg_waddr = wr_dst;
          reg_wdata = alu_res;
        end
      end

      mse_pkg::ST_ADDR: begin
        // second pass: strip the data base, then range check
        alu_req.op = mse_pkg::ALU_SUB;
        alu_req.a  = alu_q;
        alu_req.b  = mse_pkg::DATA_BASE;
        pc_d       = pc_inc;
        st_d       = mse_pkg::ST_RESP;
        if (alu_res >= mse_pkg::DATA_BYTES) begin
          status_d = mse_pkg::STS_RANGE;
        end else if (opc == mse_pkg::OPC_LW) begin
          data_re    = 1'b1;
          data_raddr = alu_res[mse_pkg::DATA_AW+1:2];
          st_d       = mse_pkg::ST_LOAD;
        end else begin
          data_we    = 1'b1;
          data_waddr = alu_res[mse_pkg::DATA_AW+1:2];
          data_wdata = b_q;
        end
      end

      mse_pkg::ST_LOAD: begin
        if (rt != 5'd0) begin
          reg_we    = 1'b1;
          reg_waddr = rt;
          reg_wdata = data_rdata;
        end
        st_d = mse_pkg::ST_RESP;
      end

      mse_pkg::ST_BR: begin
        // taken branch: pc + 1 + offset, wrapped to the counter width
        alu_req.op = mse_pkg::ALU_ADD;
        alu_req.a  = {17'd0, pc_inc};
        alu_req.b  = simm;
        pc_d       = alu_res[mse_pkg::PC_W-1:0];
        st_d       = mse_pkg::ST_RESP;
      end

      mse_pkg::ST_RESP: begin
        // hold until the result register frees up
        if (out_free) begin
          st_d = mse_pkg::ST_IDLE;
        end
      end

      default: st_d = mse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (vsel_q)
      mse_pkg::VAL_REG:  sel_value = reg_rdata;
      mse_pkg::VAL_DATA: sel_value = data_rdata;
      default:           sel_value = 32'd0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mse_pkg::ST_CLEAR;
      cnt_q       <= '0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      count_q     <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      count_q  <= count_d;
      if (cfg_wr) begin
        limit_q <= pwdata;
      end
      if ((st_q == mse_pkg::ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vsel_q   <= vsel_d;
    status_q <= status_d;
    ir_q     <= ir_d;
    a_q      <= a_d;
    b_q      <= b_d;
    alu_q    <= alu_d;
    if ((st_q == mse_pkg::ST_RESP) && out_free) begin
      out_status_q <= status_q;
      out_value_q  <= sel_value;
      out_pc_q     <= pc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_value_q;
  assign pc_index_o   = out_pc_q;

  // checks
  `MSE_ASSERT(a_halt_sticky, clk_i, rst_ni, !$fell(halted_q), "halted flag cleared")
  `MSE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_acc, st_q != mse_pkg::ST_IDLE,
                  "accepted request left no work")
  `MSE_ASSERT_IMP(a_count_on_accept, clk_i, rst_ni, !$stable(count_q), $past(in_acc),
                  "executed count moved without a request")
  `MSE_ASSERT_IMP(a_r0_kept, clk_i, rst_ni, reg_we && (st_q != mse_pkg::ST_CLEAR),
                  reg_waddr != 5'd0, "register zero written")

endmodule
`default_nettype wire

// File: src/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/mse_alu.sv
// Shared 32-bit arithmetic, logic and compare unit.
`default_nettype none
module mse_alu (
  input  wire mse_pkg::alu_req_t req_i,
  output logic [31:0]            result_o,
  output logic                   zero_o
);

  always_comb begin
    case (req_i.op)
      mse_pkg::ALU_ADD: result_o = req_i.a + req_i.b;
      mse_pkg::ALU_SUB: result_o = req_i.a - req_i.b;
      mse_pkg::ALU_AND: result_o = req_i.a & req_i.b;
      mse_pkg::ALU_OR:  result_o = req_i.a | req_i.b;
      mse_pkg::ALU_SLT: result_o = {31'd0, $signed(req_i.a) < $signed(req_i.b)};
      default:          result_o = 32'd0;
    endcase
  end

  assign zero_o = (result_o == 32'd0);

endmodule
`default_nettype wire

// File: tb/tb_mips_subset_instruction_executor.sv
`timescale 1ns / 100ps
// Testbench of the MIPS subset executor: a directed table, then random programs run against a predictor.
module tb_mips_subset_instruction_executor;
  import mse_pkg::*;

  // opcode that the core does not list; it must act as a nop
  localparam logic [5:0] OPC_SPARE      = 6'd63;
  localparam int         PRE_LIMIT_ROWS = 6;
  localparam int         RANDOM_ITEMS   = 1500;
  localparam int         SETTLE_CYCLES  = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [14:0] pc;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [14:0] idx;
    logic [31:0] word;
    bit          typed;
    result_t     res;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i        = OP_LOAD;
  logic [14:0]         index_i     = '0;
  logic [31:0]         word_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [31:0]         read_value_o;
  logic [14:0]         pc_index_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CFG_AW-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  always #5 clk_i = ~clk_i;

  mips_subset_instruction_executor dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .op_i, .index_i, .word_i,
    .out_valid_o, .out_stall_i, .status_o, .read_value_o, .pc_index_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Mirror of the core's architectural state
  bit [31:0] imem[PROGRAM_WORDS];
  bit        imem_ok[PROGRAM_WORDS];
  bit [31:0] dmem[DATA_WORDS];
  bit [31:0] gpr[REG_WORDS];
  bit [14:0] pc_m;
  bit [31:0] retired;
  bit [31:0] limit_m;
  bit        halted_m;

  result_t pending_results[$];
  row_t    rows[$];
  int      errors = 0;
  int      n_sent = 0;
  bit      quiet  = 1'b0;   // no idling on either side while set

  function automatic void write_gpr(logic [4:0] n, logic [31:0] v);
    if (n != 5'd0) gpr[n] = v;
  endfunction

  // Run the instruction at the mirrored pc; return its status code.
  function automatic logic [2:0] execute_one();
    logic [31:0] w, a, b, imm, simm, addr;
    logic [5:0]  opc;
    logic [4:0]  rs, rt, rd;
    logic [14:0] nxt;
    if (halted_m) return STS_HALTED;
    if (retired >= limit_m) return STS_LIMIT;
    retired++;
    nxt = pc_m + 15'd1;
    if (!imem_ok[pc_m]) begin
      pc_m = nxt;
      halted_m = 1'b1;
      return STS_UNKNOWN;
    end
    w    = imem[pc_m];
    opc  = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    imm  = {16'h0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    a    = gpr[rs];
    b    = gpr[rt];
    case (opc)
      OPC_RTYPE: begin
        if (w[5:0] == FN_ADD) write_gpr(rd, a + b);
        else if (w[5:0] == FN_SUB) write_gpr(rd, a - b);
        else if (w[5:0] == FN_AND) write_gpr(rd, a & b);
        else if (w[5:0] == FN_OR) write_gpr(rd, a | b);
        else if (w[5:0] == FN_SLT) write_gpr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
        else if (!(w[5:0] == FN_NOP && w[25:6] == 20'd0)) begin
          pc_m = nxt;
          halted_m = 1'b1;
          return STS_UNKNOWN;
        end
      end
      OPC_ADDI: write_gpr(rt, a + simm);
      OPC_ANDI: write_gpr(rt, a & imm);
      OPC_ORI:  write_gpr(rt, a | imm);
      OPC_SLTI: write_gpr(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
      OPC_LUI:  write_gpr(rt, {w[15:0], 16'h0});
      OPC_LW, OPC_SW: begin
        addr = a + simm - DATA_BASE;
        if (addr >= DATA_BYTES) begin
          pc_m = nxt;
          return STS_RANGE;
        end
        if (opc == OPC_LW) write_gpr(rt, dmem[addr[16:2]]);
        else dmem[addr[16:2]] = b;
      end
      OPC_BEQ: if (a == b) nxt = pc_m + 15'd1 + simm[14:0];
      OPC_BNE: if (a != b) nxt = pc_m + 15'd1 + simm[14:0];
      OPC_J:   nxt = w[14:0];
      default: ;
    endcase
    pc_m = nxt;
    return STS_OK;
  endfunction

  function automatic result_t predict_result(logic [1:0] op, logic [14:0] idx,
                                             logic [31:0] word);
    result_t r;
    r = '0;
    case (op)
      OP_LOAD: begin
        imem[idx] = word;
        imem_ok[idx] = 1'b1;
      end
      OP_EXEC: r.status = execute_one();
      OP_RDREG: begin
        if (idx < REG_WORDS) r.value = gpr[idx[4:0]];
        else r.status = STS_RANGE;
      end
      default: r.value = dmem[idx];
    endcase
    r.pc = pc_m;
    return r;
  endfunction

  // Destination register: never r1, which holds the data base
  function automatic logic [4:0] pick_dst();
    return ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(2, 31));
  endfunction

  // Random instruction that never halts the core
  function automatic logic [31:0] random_instr();
    logic [5:0]  opc, fn;
    logic [15:0] imm;
    logic [4:0]  rs;
    int          k;
    imm = 16'($urandom);
    k   = $urandom_range(0, 99);
    if (k < 25) begin
      case ($urandom_range(0, 4))
        0: fn = FN_ADD;
        1: fn = FN_SUB;
        2: fn = FN_AND;
        3: fn = FN_OR;
        default: fn = FN_SLT;
      endcase
      return {OPC_RTYPE, 5'($urandom), 5'($urandom), pick_dst(), 5'($urandom), fn};
    end
    if (k < 28) return 32'h0;
    if (k < 55) begin
      case ($urandom_range(0, 4))
        0: opc = OPC_ADDI;
        1: opc = OPC_SLTI;
        2: opc = OPC_ANDI;
        3: opc = OPC_ORI;
        default: opc = OPC_LUI;
      endcase
      return {opc, 5'($urandom), pick_dst(), imm};
    end
    if (k < 75) begin
      // mostly base r1 so the access lands in range; sometimes a wild base
      rs = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'd1;
      if ($urandom_range(0, 5) != 0) imm = 16'($urandom_range(0, 16'h7FFF));
      if ($urandom_range(0, 1)) return {OPC_LW, rs, pick_dst(), imm};
      return {OPC_SW, rs, 5'($urandom), imm};
    end
    if (k < 88) begin
      // low registers so equality is frequent
      opc = $urandom_range(0, 1) ? OPC_BEQ : OPC_BNE;
      return {opc, 5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)), imm};
    end
    if (k < 96) return {OPC_J, 26'($urandom)};
    do opc = 6'($urandom);
    while (opc inside {OPC_RTYPE, OPC_J, OPC_BEQ, OPC_BNE, OPC_ADDI, OPC_SLTI,
                       OPC_ANDI, OPC_ORI, OPC_LUI, OPC_LW, OPC_SW});
    return {opc, 26'($urandom)};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Predict, queue the expectation, then hold the request until taken.
  task automatic send_request(logic [1:0] op, logic [14:0] idx, logic [31:0] word,
                              bit typed = 1'b0, result_t typed_res = '0);
    result_t r;
    r = predict_result(op, idx, word);
    pending_results.push_back(typed ? typed_res : r);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    index_i    <= idx;
    word_i     <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Drop valid and wait for every pending result, plus a margin.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic config_limit(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(4 * REG_LIMIT);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_m = v;
  endtask

  task automatic add_row(logic [1:0] op, logic [14:0] idx, logic [31:0] word,
                         bit typed = 1'b0, result_t res = '0);
    row_t r;
    r.op = op;
    r.idx = idx;
    r.word = word;
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endtask

  // Result checker; the receiver also stalls here at random.
  always @(posedge clk_i) begin : result_check
    result_t want;
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 28);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request", {29'h0, status_o}, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (read_value_o !== want.value) report_mismatch("read_value", read_value_o, want.value);
        if (pc_index_o !== want.pc) report_mismatch("pc_index", pc_index_o, want.pc);
      end
    end
  end

  initial begin : stimulus
    logic [14:0] t;
    int          k;
    for (int i = 0; i < DATA_WORDS; i++) dmem[i] = 32'hFFFF_FFFF;

    // After reset: limit is zero, memory reads all ones
    add_row(OP_EXEC, 15'h0, 32'h0, 1'b1, {STS_LIMIT, 32'h0, 15'h0});
    add_row(OP_RDMEM, 15'h0, 32'h0, 1'b1, {STS_OK, 32'hFFFF_FFFF, 15'h0});
    add_row(OP_RDMEM, 15'h7FFF, 32'hFFFF_FFFF, 1'b1, {STS_OK, 32'hFFFF_FFFF, 15'h0});
    add_row(OP_RDREG, 15'd31, 32'h0, 1'b1, {STS_OK, 32'h0, 15'h0});
    add_row(OP_RDREG, 15'h7FFF, 32'h0, 1'b1, {STS_RANGE, 32'h0, 15'h0});
    add_row(OP_RDREG, 15'd32, 32'h0, 1'b1, {STS_RANGE, 32'h0, 15'h0});
    // Short program, each word loaded then run
    add_row(OP_LOAD, 15'd0, {OPC_LUI, 5'd0, 5'd1, 16'h1000});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_LOAD, 15'd1, {OPC_ORI, 5'd0, 5'd3, 16'hFFFF});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_LOAD, 15'd2, {OPC_SW, 5'd1, 5'd3, 16'h7FFC});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_RDMEM, 15'h1FFF, 32'h0);
    // base minus four wraps below the data window
    add_row(OP_LOAD, 15'd3, {OPC_LW, 5'd1, 5'd4, 16'hFFFC});
    add_row(OP_EXEC, 15'h0, 32'h0, 1'b1, {STS_RANGE, 32'h0, 15'd4});
    add_row(OP_LOAD, 15'd4, {OPC_RTYPE, 5'd3, 5'd1, 5'd5, 5'd0, FN_ADD});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_LOAD, 15'd5, {OPC_RTYPE, 5'd3, 5'd1, 5'd6, 5'd0, FN_SLT});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_LOAD, 15'd6, {OPC_BEQ, 5'd0, 5'd0, 16'd2});
    add_row(OP_EXEC, 15'h0, 32'h0);
    add_row(OP_LOAD, 15'd9, {OPC_SPARE, 26'h3FF_FFFF});
    add_row(OP_EXEC, 15'h0, 32'h0);
    // jump to the top slot so the next advance wraps to zero
    add_row(OP_LOAD, 15'd10, {OPC_J, 26'h000_7FFF});
    add_row(OP_EXEC, 15'h7FFF, 32'hFFFF_FFFF);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (i == PRE_LIMIT_ROWS) begin
        settle();
        config_limit(32'hFFFF_FFFF);
      end
      send_request(rows[i].op, rows[i].idx, rows[i].word, rows[i].typed, rows[i].res);
    end

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      quiet = (n_sent >= 700 && n_sent < 950);
      if (n_sent >= 500 && limit_m == 32'hFFFF_FFFF) begin
        // Drain, allow a few more instructions, run past the limit, then lift it
        settle();
        config_limit(retired + 32'd4);
        repeat (8) begin
          send_request(OP_LOAD, pc_m, random_instr());
          send_request(OP_EXEC, 15'($urandom), $urandom);
        end
        settle();
        config_limit(retired);
        send_request(OP_EXEC, 15'($urandom), $urandom);
        settle();
        config_limit(32'hFFFF_FFFE);
      end
      k = $urandom_range(0, 99);
      if (k < 50) begin
        send_request(OP_LOAD, pc_m, random_instr());
        send_request(OP_EXEC, 15'($urandom), $urandom);
      end else if (k < 65) begin
        if (!imem_ok[pc_m]) send_request(OP_LOAD, pc_m, random_instr());
        send_request(OP_EXEC, 15'($urandom), $urandom);
      end else if (k < 78) begin
        send_request(OP_RDREG, ($urandom_range(0, 7) == 0) ? 15'($urandom) :
                     15'($urandom_range(0, 31)), $urandom);
      end else if (k < 93) begin
        send_request(OP_RDMEM, 15'($urandom), $urandom);
      end else begin
        send_request(OP_LOAD, 15'($urandom), random_instr());
      end
    end
    quiet = 1'b0;

    // Halt the core once: either an unloaded slot or an unknown R-type word
    if ($urandom_range(0, 1)) begin
      do t = 15'($urandom);
      while (imem_ok[t]);
      send_request(OP_LOAD, pc_m, {OPC_J, 11'($urandom), t});
      send_request(OP_EXEC, 15'h0, 32'h0);
    end else begin
      send_request(OP_LOAD, pc_m,
                   {OPC_RTYPE, 15'($urandom), 5'($urandom_range(1, 31)), FN_NOP});
    end
    send_request(OP_EXEC, 15'h0, 32'h0);
    send_request(OP_EXEC, 15'h7FFF, 32'hFFFF_FFFF);
    send_request(OP_RDREG, 15'($urandom_range(0, 31)), 32'h0);
    send_request(OP_RDMEM, 15'($urandom), 32'h0);
    send_request(OP_LOAD, 15'($urandom), $urandom);
    send_request(OP_EXEC, 15'h0, 32'h0);

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: reset clearing pass plus the slowest item stream, several times over
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
